>>> src/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open-addressing hash table: item
// layouts, request, status and probe-mode codes, and the control group of the
// probe sequencer.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int KEY_W     = 10;
  localparam int IN_VAL_W  = 32;
  localparam int OUT_VAL_W = 32;
  localparam int POS_W     = 5;
  localparam int REQ_W     = 2;
  localparam int MODE_W    = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // Probe modes; the unused code probes as linear
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

  // Result status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [KEY_W-1:0]    key;
    logic [IN_VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                 status;
    logic [POS_W-1:0]     position;
    logic [KEY_W-1:0]     key_out;
    logic [OUT_VAL_W-1:0] value_out;
  } out_item_t;

  // Control from the table engine to the probe sequencer
  typedef struct packed {
    logic              start;
    logic              advance;
    logic [MODE_W-1:0] mode;
  } probe_ctl_t;

endpackage

>>> src/oaht_probe.sv
// ----------------------------------------------------------------------------
// oaht_probe
// Probe sequencer: derives the home slot (key mod TABLE_SIZE) and, for
// double hashing, the step (key / TABLE_SIZE) reduced mod TABLE_SIZE by
// reciprocal multiplication, then steps through the probe sequence one
// slot per advance.
// ----------------------------------------------------------------------------
module oaht_probe #(
  parameter int TABLE_SIZE = 19,
  localparam int IW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  oaht_pkg::probe_ctl_t     ctl,
  input  logic [oaht_pkg::KEY_W-1:0] key,
  output logic                     ready,
  output logic [IW-1:0]            addr
);

  localparam int KW = oaht_pkg::KEY_W;
  // Rounded-up reciprocal of the table size; with a 20-bit shift the
  // quotient is exact for every 10-bit key and every table size from 2 up to 1021
  localparam int RS = 20;
  localparam int PW = KW + RS;
  localparam logic [RS-1:0] RECIP = RS'(((1 << RS) + TABLE_SIZE - 1) / TABLE_SIZE);
  localparam logic [KW-1:0] TK    = KW'(TABLE_SIZE);
  localparam logic [IW:0]   TS    = (IW + 1)'(TABLE_SIZE);

  typedef enum logic [2:0] {
    P_IDLE,
    P_QUOT,
    P_HOME,
    P_STEP,
    P_RUN
  } pstate_t;

  pstate_t         state;
  logic [KW-1:0]   key_r;
  logic [KW-1:0]   quot;     // key / TABLE_SIZE
  logic [KW-1:0]   quot2;    // quot / TABLE_SIZE
  logic            q_zero;
  logic [IW-1:0]   pos;
  logic [IW-1:0]   inc;
  logic            quad;
  logic            dbl;

  logic [PW-1:0]   key_prod;
  logic [PW-1:0]   quot_prod;
  logic [2*KW-1:0] home_full;
  logic [2*KW-1:0] step_full;
  logic [IW:0]     sum_pos;
  logic [IW-1:0]   pos_next;
  logic [IW:0]     sum_inc;
  logic [IW-1:0]   inc_next;

  // Quotients by reciprocal multiplication, remainders by multiply-subtract
  always_comb begin
    key_prod  = PW'(key_r) * PW'(RECIP);
    quot_prod = PW'(quot) * PW'(RECIP);
    home_full = (2*KW)'(key_r) - (2*KW)'(quot) * (2*KW)'(TK);
    step_full = (2*KW)'(quot) - (2*KW)'(quot2) * (2*KW)'(TK);
  end

  // Next slot and, for quadratic probing, next increment (2n+1 mod size)
  always_comb begin
    sum_pos  = {1'b0, pos} + {1'b0, inc};
    pos_next = (sum_pos >= TS) ? IW'(sum_pos - TS) : sum_pos[IW-1:0];
    sum_inc  = {1'b0, inc} + (IW + 1)'(2);
    inc_next = (sum_inc >= TS) ? IW'(sum_inc - TS) : sum_inc[IW-1:0];
  end

  assign ready = (state == P_RUN);
  assign addr  = pos;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else if (ctl.start) begin
      key_r <= key;
      quad  <= (ctl.mode == oaht_pkg::MODE_QUAD);
      dbl   <= (ctl.mode == oaht_pkg::MODE_DOUBLE);
      state <= P_QUOT;
    end else begin
      case (state)
        P_QUOT: begin
          quot  <= key_prod[PW-1:RS];
          state <= P_HOME;
        end
        P_HOME: begin
          pos    <= home_full[IW-1:0];
          quot2  <= quot_prod[PW-1:RS];
          q_zero <= (quot == '0);
          if (dbl) begin
            state <= P_STEP;
          end else begin
            inc   <= IW'(1);
            state <= P_RUN;
          end
        end
        P_STEP: begin
          // quotient mod size gives the step; a zero quotient steps by one
          inc   <= q_zero ? IW'(1) : step_full[IW-1:0];
          state <= P_RUN;
        end
        P_RUN: begin
          if (ctl.advance) begin
            pos <= pos_next;
            if (quad) begin
              inc <= inc_next;
            end
          end
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open-addressing hash table with insert, remove and search requests and
// linear, quadratic or double-hashing probe sequences.
// ----------------------------------------------------------------------------
// After reset the table runs a clearing pass, one slot a cycle, before it
// takes the first item; configuration writes are taken throughout. Items
// are handled one at a time. After the accepting cycle an item waits in
// S_HASH while the probe sequencer derives the home slot (and, in
// double-hash mode, the step), then probes the slots in turn, reading the
// slot memory in S_READ and checking and writing back in S_CHECK, and last
// hands the result to the output register in S_DONE. An unknown request
// goes straight to S_DONE. The output register lets the next item enter
// while a result still waits to be taken.
module open_addressing_hash_table #(
  parameter int TABLE_SIZE  = 19,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  oaht_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output oaht_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [oaht_pkg::MODE_W-1:0] cfg_wdata
);

  localparam int IW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
  localparam int KW = oaht_pkg::KEY_W;
  localparam logic [IW-1:0] SLOT_LAST = IW'(TABLE_SIZE - 1);
  localparam logic [IW-1:0] QUAD_LAST = IW'((TABLE_SIZE + 1) / 2 - 1);
  localparam logic [63:0]   VAL_MASK  = {64{1'b1}} >> (64 - VALUE_WIDTH);

  typedef struct packed {
    logic                   used;
    logic [KW-1:0]          key;
    logic [VALUE_WIDTH-1:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t                      state;
  logic [IW-1:0]               clr_idx;
  logic [oaht_pkg::MODE_W-1:0] mode;
  oaht_pkg::in_item_t          item;
  logic [IW-1:0]               cnt;
  oaht_pkg::out_item_t         res;

  entry_t                      mem [TABLE_SIZE];
  entry_t                      rd_data;
  logic                        we;
  logic [IW-1:0]               waddr;
  entry_t                      wdata;

  oaht_pkg::probe_ctl_t        pctl;
  logic                        probe_ready;
  logic [IW-1:0]               probe_addr;

  logic                        req_ok;
  logic                        is_insert;
  logic                        hit;
  logic                        last_probe;
  logic [63:0]                 in_val_ext;
  logic [63:0]                 rd_val_ext;
  oaht_pkg::out_item_t         fail_res;
  oaht_pkg::out_item_t         hit_res;

  oaht_probe #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_probe (
    .clk   (clk),
    .rst   (rst),
    .ctl   (pctl),
    .key   (in_data.key),
    .ready (probe_ready),
    .addr  (probe_addr)
  );

  // Probe mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= oaht_pkg::MODE_LINEAR;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // Request decode and probe outcome
  always_comb begin
    req_ok     = in_data.req_type inside {oaht_pkg::REQ_INSERT, oaht_pkg::REQ_REMOVE,
                                          oaht_pkg::REQ_SEARCH};
    is_insert  = (item.req_type == oaht_pkg::REQ_INSERT);
    hit        = is_insert ? !rd_data.used : (rd_data.used && (rd_data.key == item.key));
    last_probe = (cnt == ((mode == oaht_pkg::MODE_QUAD) ? QUAD_LAST : SLOT_LAST));
    in_val_ext = 64'(item.value) & VAL_MASK;
    rd_val_ext = 64'(rd_data.value);
  end

  // Result words
  always_comb begin
    fail_res.status    = oaht_pkg::STATUS_FAIL;
    fail_res.position  = '0;
    fail_res.key_out   = item.key;
    fail_res.value_out = '0;
    hit_res.status     = oaht_pkg::STATUS_DONE;
    hit_res.position   = oaht_pkg::POS_W'(probe_addr);
    hit_res.key_out    = item.key;
    hit_res.value_out  = is_insert ? in_val_ext[oaht_pkg::OUT_VAL_W-1:0]
                                   : rd_val_ext[oaht_pkg::OUT_VAL_W-1:0];
  end

  // Probe sequencer control
  always_comb begin
    pctl.start   = (state == S_IDLE) && in_valid && req_ok;
    pctl.advance = (state == S_CHECK) && !hit && !last_probe;
    pctl.mode    = mode;
  end

  assign in_ready = (state == S_IDLE);

  // Memory write port: clearing pass, or write-back of an insert or remove hit
  always_comb begin
    we    = 1'b0;
    waddr = probe_addr;
    wdata = rd_data;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else if ((state == S_CHECK) && hit) begin
      if (is_insert) begin
        we          = 1'b1;
        wdata.used  = 1'b1;
        wdata.key   = item.key;
        wdata.value = in_val_ext[VALUE_WIDTH-1:0];
      end else if (item.req_type == oaht_pkg::REQ_REMOVE) begin
        we         = 1'b1;
        wdata.used = 1'b0;
      end
    end
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[probe_addr];
  end

  // Control FSM and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a finished result, or drop one that was taken
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == SLOT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            cnt  <= '0;
            if (req_ok) begin
              state <= S_HASH;
            end else begin
              // unknown request: fail at once, nothing touched
              res.status    <= oaht_pkg::STATUS_FAIL;
              res.position  <= '0;
              res.key_out   <= in_data.key;
              res.value_out <= '0;
              state         <= S_DONE;
            end
          end
        end
        S_HASH: begin
          if (probe_ready) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (hit) begin
            res   <= hit_res;
            state <= S_DONE;
          end else if (last_probe) begin
            res   <= fail_res;
            state <= S_DONE;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/tb_open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// tb_open_addressing_hash_table
// Self-checking bench for the open-addressing hash table. Requests stream
// through a valid/ready driver. A shadow copy of the slot store predicts
// each result when its request is accepted. Results are compared field by
// field in order. The probe mode is changed between idle phases.
// ----------------------------------------------------------------------------
module tb_open_addressing_hash_table;
  import oaht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE  = 19;
  localparam int VALUE_WIDTH = 32;
  localparam int POOL_SIZE   = 16;
  localparam int IDLE_SETTLE = 70;  // longer than a full double-hash walk
  localparam int END_DRAIN   = 80;

  // Codes the package leaves unnamed
  localparam logic [REQ_W-1:0]  REQ_NONE    = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic              cfg_we = 1'b0;
  logic [MODE_W-1:0] cfg_wdata = '0;

  // Shadow of the slot store and the probe mode
  bit                  tbl_used [TABLE_SIZE];
  logic [KEY_W-1:0]    tbl_key  [TABLE_SIZE];
  logic [IN_VAL_W-1:0] tbl_val  [TABLE_SIZE];
  logic [MODE_W-1:0]   tbl_mode = MODE_LINEAR;

  in_item_t  request_queue [$];
  out_item_t awaited_results [$];
  out_item_t got_res;
  out_item_t want_res;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned      cluster_a;
  int unsigned      cluster_b;
  bit               steady = 1'b0;
  bit               failed = 1'b0;
  int unsigned      send_gap = 0;
  int unsigned      stall_left = 0;

  open_addressing_hash_table #(
    .TABLE_SIZE (TABLE_SIZE),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Walk the probe sequence; returns the slot that fits, or -1
  function automatic int probe_slot(logic [KEY_W-1:0] k, bit want_empty);
    int unsigned step;
    int unsigned limit;
    int unsigned off;
    int unsigned p;
    step  = 1;
    limit = TABLE_SIZE;
    if (tbl_mode == MODE_DOUBLE) begin
      step = int'(k) / TABLE_SIZE;
      if (step == 0) step = 1;
    end else if (tbl_mode == MODE_QUAD) begin
      limit = (TABLE_SIZE + 1) / 2;
    end
    for (int unsigned n = 0; n < limit; n++) begin
      off = (tbl_mode == MODE_QUAD) ? n * n : step * n;
      p   = (int'(k) + off) % TABLE_SIZE;
      if (want_empty) begin
        if (!tbl_used[p]) return int'(p);
      end else begin
        if (tbl_used[p] && tbl_key[p] == k) return int'(p);
      end
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return its result
  function automatic out_item_t apply_request(in_item_t it);
    out_item_t r;
    int        slot;
    r.status    = STATUS_FAIL;
    r.position  = '0;
    r.key_out   = it.key;
    r.value_out = '0;
    case (it.req_type)
      REQ_INSERT: begin
        slot = probe_slot(it.key, 1'b1);
        if (slot >= 0) begin
          tbl_used[slot] = 1'b1;
          tbl_key[slot]  = it.key;
          tbl_val[slot]  = it.value;
          r.status       = STATUS_DONE;
          r.position     = POS_W'(slot);
          r.value_out    = it.value;
        end
      end
      REQ_REMOVE, REQ_SEARCH: begin
        slot = probe_slot(it.key, 1'b0);
        if (slot >= 0) begin
          r.status    = STATUS_DONE;
          r.position  = POS_W'(slot);
          r.value_out = tbl_val[slot];
          if (it.req_type == REQ_REMOVE) tbl_used[slot] = 1'b0;
        end
      end
      default: ;  // unused request type leaves the table alone
    endcase
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none in a steady phase
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Keys crowd onto two home slots so that probe chains get long
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned base;
    if ($urandom_range(0, 9) < 3) return KEY_W'($urandom_range(0, 1023));
    base = ($urandom_range(0, 1) != 0) ? cluster_a : cluster_b;
    return KEY_W'(base + TABLE_SIZE * $urandom_range(0, (1023 - base) / TABLE_SIZE));
  endfunction

  function automatic in_item_t make_req(logic [REQ_W-1:0] rt, int unsigned k,
                                        logic [IN_VAL_W-1:0] v);
    in_item_t it;
    it.req_type = rt;
    it.key      = KEY_W'(k);
    it.value    = v;
    return it;
  endfunction

  function automatic in_item_t random_request(int unsigned ins_pct, int unsigned rem_pct);
    int unsigned      roll;
    logic [REQ_W-1:0] rt;
    logic [KEY_W-1:0] k;
    roll = $urandom_range(0, 99);
    if (roll < 3) rt = REQ_NONE;
    else if (roll < 3 + ins_pct) rt = REQ_INSERT;
    else if (roll < 3 + ins_pct + rem_pct) rt = REQ_REMOVE;
    else rt = REQ_SEARCH;
    if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else k = KEY_W'($urandom_range(0, 1023));
    return make_req(rt, k, $urandom());
  endfunction

  // Block until the table holds no work, then let it settle
  task automatic wait_idle();
    @(posedge clk);
    while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] m);
    wait_idle();
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tbl_mode  = m;
  endtask

  task automatic run_random(logic [MODE_W-1:0] m, int unsigned n,
                            int unsigned ins_pct, int unsigned rem_pct);
    write_mode(m);
    steady    = ($urandom_range(0, 3) == 0);
    cluster_a = $urandom_range(0, TABLE_SIZE - 1);
    cluster_b = $urandom_range(0, TABLE_SIZE - 1);
    // refresh part of the pool, keep the rest so old records get hit
    for (int i = 0; i < POOL_SIZE; i++)
      if ($urandom_range(0, 2) == 0) key_pool[i] = pick_key();
    repeat (n) request_queue.push_back(random_request(ins_pct, rem_pct));
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_ready) begin
      // hold the item until it is taken
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (request_queue.size() != 0) begin
      in_data  <= request_queue.pop_front();
      in_valid <= 1'b1;
      send_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  // Predict at acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) awaited_results.push_back(apply_request(in_data));
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_res = out_data;
      if (awaited_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %p", $time, got_res);
        failed = 1'b1;
      end else begin
        want_res = awaited_results.pop_front();
        check_field("status", 32'(want_res.status), 32'(got_res.status));
        check_field("position", 32'(want_res.position), 32'(got_res.position));
        check_field("key_out", 32'(want_res.key_out), 32'(got_res.key_out));
        check_field("value_out", 32'(want_res.value_out), 32'(got_res.value_out));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom_range(0, 1023));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, collisions, extremes, duplicates, no tombstone
    write_mode(MODE_LINEAR);
    request_queue.push_back(make_req(REQ_SEARCH, 0, 32'h0));
    request_queue.push_back(make_req(REQ_REMOVE, 5, 32'hFFFF_FFFF));
    request_queue.push_back(make_req(REQ_INSERT, 0, 32'h0));
    request_queue.push_back(make_req(REQ_INSERT, 19, 32'hFFFF_FFFF));
    request_queue.push_back(make_req(REQ_INSERT, 38, 32'h1234_5678));
    request_queue.push_back(make_req(REQ_INSERT, 1023, 32'hA5A5_A5A5));
    request_queue.push_back(make_req(REQ_INSERT, 999, 32'h5A5A_5A5A));
    request_queue.push_back(make_req(REQ_INSERT, 7, 32'h1));
    request_queue.push_back(make_req(REQ_INSERT, 7, 32'h2));
    request_queue.push_back(make_req(REQ_SEARCH, 7, 32'h0));
    request_queue.push_back(make_req(REQ_REMOVE, 0, 32'h0));
    request_queue.push_back(make_req(REQ_SEARCH, 19, 32'h0));
    request_queue.push_back(make_req(REQ_SEARCH, 38, 32'h0));
    request_queue.push_back(make_req(REQ_REMOVE, 0, 32'h0));
    request_queue.push_back(make_req(REQ_NONE, 5, 32'hDEAD_BEEF));
    request_queue.push_back(make_req(REQ_SEARCH, 1000, 32'h0));
    request_queue.push_back(make_req(REQ_INSERT, 1000, 32'hC0FF_EE00));

    // Double hashing with a step that is a multiple of the table size
    write_mode(MODE_DOUBLE);
    request_queue.push_back(make_req(REQ_INSERT, 361, 32'h0000_0361));
    request_queue.push_back(make_req(REQ_INSERT, 361, 32'h0000_0362));
    request_queue.push_back(make_req(REQ_SEARCH, 361, 32'h0));
    request_queue.push_back(make_req(REQ_REMOVE, 361, 32'h0));
    request_queue.push_back(make_req(REQ_SEARCH, 361, 32'h0));
    request_queue.push_back(make_req(REQ_INSERT, 40, 32'h0000_0040));

    // Random phases across all modes; insert-heavy fills, remove-heavy drains
    run_random(MODE_QUAD, 75, 60, 15);
    run_random(MODE_DOUBLE, 75, 45, 25);
    run_random(MODE_UNUSED, 75, 30, 40);
    run_random(MODE_LINEAR, 75, 65, 10);
    run_random(MODE_DOUBLE, 75, 35, 35);
    run_random(MODE_QUAD, 75, 40, 30);

    wait_idle();
    repeat (END_DRAIN) @(posedge clk);
    if (!failed && awaited_results.size() == 0) begin
      $display("open_addressing_hash_table test passed");
    end else begin
      $display("open_addressing_hash_table test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("open_addressing_hash_table test failed");
    $finish;
  end

endmodule
